// ===== rtl/iosa_pkg.sv =====
// ----------------------------------------------------------------------------
// iosa_pkg
// shared types and constants of the interleaved oversample accumulator
// ----------------------------------------------------------------------------
package iosa_pkg;

	localparam int SLOT_COUNT        = 8;
	localparam int SLOT_W            = 3;
	localparam int SAMPLE_W          = 16;
	localparam int SUM_W             = 28;
	localparam int SRC_W             = 3;
	localparam int MASK_W            = 8;
	localparam int CNT_W             = 4;
	localparam int ROUND_W           = 13;
	localparam int SOURCES_W         = 24;
	localparam int LIM_W             = 17;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 64;
	localparam int OUT_TDATA_W       = 40;

	localparam int MAX_CHANNELS      = 8;
	localparam int MAX_BLOCK_SAMPLES = 4096;
	localparam int MAX_STEPS         = 8;
	localparam int CHAN_LIM          = (MAX_CHANNELS < SLOT_COUNT) ? MAX_CHANNELS : SLOT_COUNT;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// block sample limit divided by the effective channel count, entry k for k+1 channels
	localparam logic [LIM_W-1:0] ROUND_LIM [SLOT_COUNT] = '{
		LIM_W'(MAX_BLOCK_SAMPLES / 1), LIM_W'(MAX_BLOCK_SAMPLES / 2),
		LIM_W'(MAX_BLOCK_SAMPLES / 3), LIM_W'(MAX_BLOCK_SAMPLES / 4),
		LIM_W'(MAX_BLOCK_SAMPLES / 5), LIM_W'(MAX_BLOCK_SAMPLES / 6),
		LIM_W'(MAX_BLOCK_SAMPLES / 7), LIM_W'(MAX_BLOCK_SAMPLES / 8)
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT    = 3'd0,
		REG_ROUNDS_PER_BLOCK = 3'd1,
		REG_CHANNEL_SOURCES  = 3'd2,
		REG_FLASH_MODE       = 3'd3,
		REG_STEP_COUNT       = 3'd4,
		REG_STEP_MASKS       = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic [SLOT_W-1:0]   slot;
		logic [SRC_W-1:0]    src;
		logic                last_round;
		logic                emit;
	} item_t;

endpackage

// ===== rtl/iosa_seq.sv =====
// ----------------------------------------------------------------------------
// iosa_seq
// configuration registers, slot/round/step sequencing and the input stage
// ----------------------------------------------------------------------------
module iosa_seq import iosa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic [SAMPLE_W-1:0]   sample_value,
	input  logic                  advance,
	output logic                  valid_s1,
	output item_t                 item_s1
);

	logic [CNT_W-1:0]     channel_count_q;
	logic [ROUND_W-1:0]   rounds_per_block_q;
	logic [SOURCES_W-1:0] channel_sources_q;
	logic                 flash_mode_q;
	logic [CNT_W-1:0]     step_count_q;
	logic [CFG_DATA_W-1:0] step_masks_q;

	logic [SLOT_W-1:0]    slot_q;
	logic [ROUND_W-1:0]   round_q;
	logic [SLOT_W-1:0]    step_q;

	logic [CNT_W-1:0]     chans;
	logic [SLOT_W-1:0]    chan_idx;
	logic [LIM_W-1:0]     lim;
	logic [ROUND_W-1:0]   rounds;
	logic [CNT_W-1:0]     steps;
	logic [CNT_W-1:0]     step_inc;
	logic                 last_round;
	logic                 last_slot;
	logic [SRC_W-1:0]     src;
	logic [MASK_W-1:0]    mask;
	item_t                item_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q    <= CNT_W'(1);
			rounds_per_block_q <= ROUND_W'(1);
			channel_sources_q  <= '0;
			flash_mode_q       <= 1'b0;
			step_count_q       <= CNT_W'(1);
			step_masks_q       <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CHANNEL_COUNT:    channel_count_q    <= cfg_data[CNT_W-1:0];
				REG_ROUNDS_PER_BLOCK: rounds_per_block_q <= cfg_data[ROUND_W-1:0];
				REG_CHANNEL_SOURCES:  channel_sources_q  <= cfg_data[SOURCES_W-1:0];
				REG_FLASH_MODE:       flash_mode_q       <= cfg_data[0];
				REG_STEP_COUNT:       step_count_q       <= cfg_data[CNT_W-1:0];
				REG_STEP_MASKS:       step_masks_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		chans = channel_count_q;
		if (chans == '0)
			chans = CNT_W'(1);
		if (chans > CNT_W'(CHAN_LIM))
			chans = CNT_W'(CHAN_LIM);
		chan_idx = SLOT_W'(chans - CNT_W'(1));

		lim = ROUND_LIM[chan_idx];
		if (lim == '0)
			lim = LIM_W'(1);
		rounds = rounds_per_block_q;
		if (rounds == '0)
			rounds = ROUND_W'(1);
		if (LIM_W'(rounds) > lim)
			rounds = ROUND_W'(lim);

		steps = step_count_q;
		if (steps == '0)
			steps = CNT_W'(1);
		if (steps > CNT_W'(MAX_STEPS))
			steps = CNT_W'(MAX_STEPS);
		step_inc = CNT_W'(step_q) + CNT_W'(1);

		last_round = round_q >= (rounds - ROUND_W'(1));
		last_slot  = CNT_W'(slot_q) >= (chans - CNT_W'(1));
		src        = channel_sources_q[SRC_W*slot_q +: SRC_W];
		mask       = step_masks_q[MASK_W*step_q +: MASK_W];

		item_d.value      = sample_value;
		item_d.slot       = slot_q;
		item_d.src        = src;
		item_d.last_round = last_round;
		item_d.emit       = last_round && (!flash_mode_q || mask[src]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			round_q <= '0;
			step_q  <= '0;
		end else if (accept) begin
			if (last_slot) begin
				slot_q <= '0;
				if (last_round) begin
					round_q <= '0;
					if (flash_mode_q)
						step_q <= (step_inc >= steps) ? '0 : step_inc[SLOT_W-1:0];
				end else begin
					round_q <= round_q + ROUND_W'(1);
				end
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept || (valid_s1 && !advance);
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item_d;
	end

endmodule

// ===== rtl/iosa_acc.sv =====
// ----------------------------------------------------------------------------
// iosa_acc
// per-slot running sums and the result register
// ----------------------------------------------------------------------------
module iosa_acc import iosa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  item_t             item_s1,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [SLOT_W-1:0] out_slot,
	output logic [SRC_W-1:0]  out_src,
	output logic [SUM_W-1:0]  out_sum
);

	logic [SUM_W-1:0] sums_q [SLOT_COUNT];
	logic [SUM_W:0]   raw_sum;
	logic [SUM_W-1:0] sat_sum;

	always_comb begin
		raw_sum = {1'b0, sums_q[item_s1.slot]} + (SUM_W+1)'(item_s1.value);
		sat_sum = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
	end

	// sum is cleared once the block for the slot ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++)
				sums_q[i] <= '0;
		end else if (advance) begin
			sums_q[item_s1.slot] <= item_s1.last_round ? '0 : sat_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (advance && item_s1.emit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.emit) begin
			out_slot <= item_s1.slot;
			out_src  <= item_s1.src;
			out_sum  <= sat_sum;
		end
	end

endmodule

// ===== rtl/interleaved_oversample_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// interleaved_oversample_accumulator_top
// sums round-robin interleaved samples per slot and emits block sums
// ----------------------------------------------------------------------------
// an accepted sample goes to the input stage, its block sum to the result register
// throughput: one sample per cycle, set by the single read-modify-write of the slot sum
// the input stage stalls only while a block sum waits in the result register
// arst_n clears registers, sums, positions and step index to their initial values
module interleaved_oversample_accumulator_top import iosa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [SAMPLE_W-1:0]    s_tdata,   // sample_value
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // slot, source_id, block_sum, zero pad
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic              accept;
	logic              advance;
	logic              valid_s1;
	item_t             item_s1;
	logic [SLOT_W-1:0] out_slot;
	logic [SRC_W-1:0]  out_src;
	logic [SUM_W-1:0]  out_sum;

	// the input stage moves on unless its word must wait for the result register
	assign advance  = valid_s1 && (!item_s1.emit || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	iosa_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.sample_value (s_tdata),
		.advance      (advance),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	iosa_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_slot  (out_slot),
		.out_src   (out_src),
		.out_sum   (out_sum)
	);

	assign m_tdata = {{(OUT_TDATA_W - SUM_W - SRC_W - SLOT_W){1'b0}}, out_sum, out_src, out_slot};

`ifndef SYNTHESIS
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (m_tvalid && !m_tready))
		else $error("input stage stalled without a blocked result");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && item_s1.emit))
		else $error("result appeared without an emitting word");

	a_not_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input refused while the stage is empty");
`endif

endmodule
